// ===== hdl/rhc_pkg.sv =====
package rhc_pkg;

  localparam logic [14:0] HUE_SECTOR = 15'd3840;
  localparam logic [14:0] HUE_FULL   = 15'd23040;
  localparam int          DIV_STEPS  = 16;
  localparam int          Q_DEPTH    = 4;
  localparam int          Q_AW       = $clog2(Q_DEPTH);

  localparam logic [1:0] SEC_R = 2'd0;
  localparam logic [1:0] SEC_G = 2'd1;
  localparam logic [1:0] SEC_B = 2'd2;

  localparam logic [20:0] RECIP15 = 21'd1118482;

  typedef struct packed {
    logic        func;
    logic [15:0] mx;
    logic [15:0] delta;
    logic [15:0] d;
    logic        neg;
    logic [1:0]  sec;
    logic [15:0] v;
    logic [15:0] s;
    logic [11:0] t;
    logic [2:0]  hsec;
  } fe_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qst_t;

  typedef struct packed {
    logic [31:0] n;
    logic [15:0] r;
    logic [15:0] q;
  } dv_t;

  typedef struct packed {
    logic        func;
    logic [15:0] mx;
    logic [15:0] delta;
    logic        neg;
    logic [1:0]  sec;
    dv_t         sd;
    dv_t         hd;
    logic [40:0] p;
    logic [15:0] v;
    logic [15:0] c;
    logic [15:0] x;
    logic [11:0] t;
    logic [2:0]  hsec;
  } bk_t;

  function automatic dv_t div_step(dv_t a, logic [15:0] dvs);
    logic [16:0] r2;
    dv_t         o;
    r2  = {a.r, a.n[31]};
    o.n = {a.n[30:0], 1'b0};
    if (r2 >= {1'b0, dvs}) begin
      o.r = 16'(r2 - {1'b0, dvs});
      o.q = {a.q[14:0], 1'b1};
    end else begin
      o.r = r2[15:0];
      o.q = {a.q[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_init(logic [31:0] num);
    dv_t o;
    o.r = num[31:16];
    o.n = {num[15:0], 16'b0};
    o.q = '0;
    return o;
  endfunction

endpackage

// ===== hdl/rgb_hsv_color_converter.sv =====
// An accepted transaction passes the classify register, the queue, the divider
// pipeline and the result register. Throughput: one transaction per cycle,
// set by the 16-step pipelined divider, unless a result waits for out_pop.
// A 4-entry queue decouples the classify stage from the divider pipeline.
// Reset: rst_n is synchronous, active low; it empties the queue and pipeline.
module rgb_hsv_color_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [14:0] in_hue,
  input  logic [15:0] in_saturation,
  input  logic [15:0] in_brightness,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [14:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [15:0] out_brightness
);
  import rhc_pkg::*;

  qst_t qstat;
  fe_t  wr_data, rd_data;
  logic q_wr, q_rd;

  rhc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_red, .in_green, .in_blue,
    .in_hue, .in_saturation, .in_brightness,
    .qstat(qstat), .q_wr(q_wr), .q_data(wr_data)
  );

  rhc_queue u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(wr_data), .rd_en(q_rd),
    .rd_data(rd_data), .stat(qstat)
  );

  rhc_back u_back (
    .clk, .rst_n, .qstat(qstat), .q_data(rd_data), .q_rd(q_rd),
    .out_empty, .out_pop, .out_red, .out_green, .out_blue, .out_hue,
    .out_saturation, .out_brightness
  );

endmodule

// ===== hdl/rhc_queue.sv =====
module rhc_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  rhc_pkg::fe_t wr_data,
  input  logic         rd_en,
  output rhc_pkg::fe_t rd_data,
  output rhc_pkg::qst_t stat
);
  import rhc_pkg::*;

  fe_t           mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_wr) - (Q_AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/rhc_front.sv =====
module rhc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_func,
  input  logic [15:0]   in_red,
  input  logic [15:0]   in_green,
  input  logic [15:0]   in_blue,
  input  logic [14:0]   in_hue,
  input  logic [15:0]   in_saturation,
  input  logic [15:0]   in_brightness,
  input  rhc_pkg::qst_t qstat,
  output logic          q_wr,
  output rhc_pkg::fe_t  q_data
);
  import rhc_pkg::*;

  fe_t         fe_r, fe_nxt;
  logic        vld_r, vld_nxt;
  logic        accept;
  logic [15:0] mn, pp, nn;
  logic [14:0] h, f, base;

  assign in_full = vld_r && qstat.full;
  assign accept  = in_push && !in_full;
  assign q_wr    = vld_r && !qstat.full;
  assign q_data  = fe_r;
  assign vld_nxt = accept || (vld_r && !q_wr);

  always_comb begin
    fe_nxt      = '0;
    fe_nxt.func = in_func;
    if (in_red >= in_green && in_red >= in_blue) begin
      fe_nxt.mx  = in_red;
      fe_nxt.sec = SEC_R;
      pp         = in_green;
      nn         = in_blue;
    end else if (in_green >= in_blue) begin
      fe_nxt.mx  = in_green;
      fe_nxt.sec = SEC_G;
      pp         = in_blue;
      nn         = in_red;
    end else begin
      fe_nxt.mx  = in_blue;
      fe_nxt.sec = SEC_B;
      pp         = in_red;
      nn         = in_green;
    end
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    fe_nxt.delta = fe_nxt.mx - mn;
    fe_nxt.neg   = pp < nn;
    fe_nxt.d     = fe_nxt.neg ? nn - pp : pp - nn;

    h = (in_hue >= HUE_FULL) ? in_hue - HUE_FULL : in_hue;
    priority if (h >= 15'd19200) fe_nxt.hsec = 3'd5;
    else if (h >= 15'd15360)     fe_nxt.hsec = 3'd4;
    else if (h >= 15'd11520)     fe_nxt.hsec = 3'd3;
    else if (h >= 15'd7680)      fe_nxt.hsec = 3'd2;
    else if (h >= HUE_SECTOR)    fe_nxt.hsec = 3'd1;
    else                         fe_nxt.hsec = 3'd0;
    unique case (fe_nxt.hsec)
      3'd0:    base = 15'd0;
      3'd1:    base = 15'd3840;
      3'd2:    base = 15'd7680;
      3'd3:    base = 15'd11520;
      3'd4:    base = 15'd15360;
      default: base = 15'd19200;
    endcase
    f        = h - base;
    fe_nxt.t = fe_nxt.hsec[0] ? 12'(HUE_SECTOR - f) : f[11:0];
    fe_nxt.v = in_brightness;
    fe_nxt.s = in_saturation;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_r <= fe_nxt;
    end
  end

endmodule

// ===== hdl/rhc_back.sv =====
module rhc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rhc_pkg::qst_t qstat,
  input  rhc_pkg::fe_t  q_data,
  output logic          q_rd,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [15:0]   out_red,
  output logic [15:0]   out_green,
  output logic [15:0]   out_blue,
  output logic [14:0]   out_hue,
  output logic [15:0]   out_saturation,
  output logic [15:0]   out_brightness
);
  import rhc_pkg::*;

  bk_t              stg_r   [0:DIV_STEPS];
  bk_t              stg_nxt [0:DIV_STEPS];
  logic [DIV_STEPS:0] vld_r;
  logic             ovld_r;
  logic             adv;
  bk_t              e;
  logic [15:0] red_r, green_r, blue_r, sat_r, bri_r;
  logic [14:0] hue_r;
  logic [15:0] red_nxt, green_nxt, blue_nxt, sat_nxt, bri_nxt, m, cm, xm, hbase, hraw;
  logic [14:0] hue_nxt;

  assign adv       = !ovld_r || out_pop;
  assign q_rd      = adv && !qstat.empty;
  assign out_empty = !ovld_r;

  always_comb begin
    stg_nxt[0]       = '0;
    stg_nxt[0].func  = q_data.func;
    stg_nxt[0].mx    = q_data.mx;
    stg_nxt[0].delta = q_data.delta;
    stg_nxt[0].neg   = q_data.neg;
    stg_nxt[0].sec   = q_data.sec;
    stg_nxt[0].sd    = div_init(({q_data.delta, 16'b0} - 32'(q_data.delta))
                                + 32'(q_data.mx[15:1]));
    stg_nxt[0].hd    = div_init(32'(q_data.d) * 32'(HUE_SECTOR)
                                + 32'(q_data.delta[15:1]));
    stg_nxt[0].p     = 41'(32'(q_data.v) * 32'(q_data.s)) + 41'd32767;
    stg_nxt[0].v     = q_data.v;
    stg_nxt[0].t     = q_data.t;
    stg_nxt[0].hsec  = q_data.hsec;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_stage
    always_comb begin
      stg_nxt[k]    = stg_r[k-1];
      stg_nxt[k].sd = div_step(stg_r[k-1].sd, stg_r[k-1].mx);
      stg_nxt[k].hd = div_step(stg_r[k-1].hd, stg_r[k-1].delta);
      if (k == 1) begin
        stg_nxt[k].c = 16'((34'(stg_r[k-1].p[31:0]) + 34'(stg_r[k-1].p[31:16])
                           + 34'd1) >> 16);
      end
      if (k == 2) begin
        stg_nxt[k].p = 41'(32'(stg_r[k-1].c) * 32'(stg_r[k-1].t)) + 41'd1920;
      end
      if (k == 3) begin
        stg_nxt[k].p = 41'(stg_r[k-1].p[27:8]) * 41'(RECIP15);
      end
      if (k == 4) begin
        stg_nxt[k].x = stg_r[k-1].p[39:24];
      end
    end
  end

  for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= {vld_r[DIV_STEPS-1:0], !qstat.empty};
      ovld_r <= vld_r[DIV_STEPS];
    end
  end

  always_comb begin
    e         = stg_r[DIV_STEPS];
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    sat_nxt   = '0;
    bri_nxt   = '0;
    hue_nxt   = '0;
    m         = e.v - e.c;
    cm        = e.c + m;
    xm        = e.x + m;
    unique case (e.sec)
      SEC_R:   hbase = 16'd0;
      SEC_G:   hbase = 16'd7680;
      default: hbase = 16'd15360;
    endcase
    if (!e.neg) begin
      hraw = hbase + e.hd.q;
    end else if (hbase >= e.hd.q) begin
      hraw = hbase - e.hd.q;
    end else begin
      hraw = hbase + 16'(HUE_FULL) - e.hd.q;
    end
    if (hraw >= 16'(HUE_FULL)) hraw = hraw - 16'(HUE_FULL);
    if (!e.func) begin
      bri_nxt = e.mx;
      if (e.mx != '0) begin
        sat_nxt = e.sd.q;
        if (e.delta != '0) hue_nxt = hraw[14:0];
      end
    end else begin
      unique case (e.hsec)
        3'd0: begin red_nxt = cm; green_nxt = xm; blue_nxt = m;  end
        3'd1: begin red_nxt = xm; green_nxt = cm; blue_nxt = m;  end
        3'd2: begin red_nxt = m;  green_nxt = cm; blue_nxt = xm; end
        3'd3: begin red_nxt = m;  green_nxt = xm; blue_nxt = cm; end
        3'd4: begin red_nxt = xm; green_nxt = m;  blue_nxt = cm; end
        default: begin red_nxt = cm; green_nxt = m; blue_nxt = xm; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      bri_r   <= bri_nxt;
    end
  end

  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_hue < HUE_FULL)
    else $error("hue out of range");
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_hue != '0 || out_saturation != '0 || out_brightness != '0))
    |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("both directions driven");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_pop) |=> (ovld_r && $stable(hue_r) && $stable(red_r)))
    else $error("result lost under stall");
`endif

endmodule
